// ===== rtl/core/mss_pkg.sv =====
// Package: signature table, sizes and status codes for the signature scanner.
package mss_pkg;

  localparam int SIG_WORDS  = 14;
  localparam int ADDR_BITS  = 48;
  localparam int WORD_BITS  = 32;
  localparam int WIN_DEPTH  = SIG_WORDS - 1;
  localparam int FILL_BITS  = $clog2(WIN_DEPTH + 1);
  localparam int ADDR_BACK  = 4 * WIN_DEPTH;

  typedef enum logic [1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_UNIQUE = 2'd1,
    STATUS_MULTI  = 2'd2
  } match_status_t;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam word_t SIG_VALUE [SIG_WORDS] = '{
    32'ha9be7bfd, 32'h910003fd, 32'ha90153f3, 32'haa0003f4,
    32'h9100c013, 32'haa1303e0, 32'h94000000, 32'hb9400a94,
    32'haa1303e0, 32'h94000000, 32'h2a1403e0, 32'ha94153f3,
    32'ha8c27bfd, 32'hd65f03c0
  };

  // branch-and-link words compare the opcode only
  localparam word_t SIG_MASK [SIG_WORDS] = '{
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'hffffffff, 32'hffffffff, 32'hfc000000, 32'hffffffff,
    32'hffffffff, 32'hfc000000, 32'hffffffff, 32'hffffffff,
    32'hffffffff, 32'hffffffff
  };

endpackage

// ===== rtl/core/masked_signature_scanner.sv =====
// Top level: masked multiword signature scanner over an instruction word stream.
//
// Usage:
//   Input channel (in_*): one instruction word per beat with its byte address,
//   a segment-start flag and a scan-end flag. A beat is taken when in_valid
//   is high and in_stall is low.
//   Result channel (out_*): one beat per scan, produced by the scan-end word:
//   status (none, unique, multiple) and the address of the first signature
//   word when the match is unique, zero otherwise.
//   Throughput: one word per cycle while in_stall is low. All masked compares
//   of the window and the incoming word run in parallel, combinationally.
//   Latency: the result is valid the cycle after the scan-end word is taken.
//   Stall: the result register holds while out_stall is high; in_stall rises
//   only when a scan-end word is offered while a result is held and stalled,
//   so other words keep flowing.
//   Reset: rst_n (synchronous, active low) clears fill count, match tally,
//   stored address and the result valid. Window words are not cleared; they
//   are only compared once the fill count shows them written.
module masked_signature_scanner (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              in_text_word,
  input  logic [47:0]              in_word_address,
  input  logic                     in_segment_start,
  input  logic                     in_scan_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_match_status,
  output logic [47:0]              out_match_address
);
  import mss_pkg::*;

  word_t                window_r [WIN_DEPTH];
  logic [FILL_BITS-1:0] fill_r, fill_nxt, fill_eff;
  logic [1:0]           tally_r, tally_nxt, tally_hit;
  addr_t                found_r, found_nxt, found_hit;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           status_r, status_nxt;
  addr_t                addr_out_r, addr_out_nxt;

  logic                 accept, hit, out_take;
  word_t                cand [SIG_WORDS];
  logic [SIG_WORDS-1:0] pos_ok;

  assign out_take = out_valid_r && !out_stall;
  // only a scan-end word needs the result register
  assign in_stall = out_valid_r && out_stall && in_scan_end;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      cand[k] = window_r[k];
    end
    cand[WIN_DEPTH] = in_text_word;
    for (int k = 0; k < SIG_WORDS; k++) begin
      pos_ok[k] = (cand[k] & SIG_MASK[k]) == SIG_VALUE[k];
    end
  end

  always_comb begin
    fill_eff  = in_segment_start ? '0 : fill_r;
    hit       = (fill_eff >= FILL_BITS'(WIN_DEPTH)) && (&pos_ok);
    tally_hit = tally_r;
    found_hit = found_r;
    if (hit) begin
      if (tally_r == STATUS_NONE) begin
        found_hit = in_word_address - ADDR_BITS'(ADDR_BACK);
      end
      if (tally_r != STATUS_MULTI) begin
        tally_hit = tally_r + 2'd1;
      end
    end

    fill_nxt      = fill_r;
    tally_nxt     = tally_r;
    found_nxt     = found_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    status_nxt    = status_r;
    addr_out_nxt  = addr_out_r;

    if (accept) begin
      fill_nxt  = (fill_eff < FILL_BITS'(WIN_DEPTH)) ? fill_eff + 1'b1 : fill_eff;
      tally_nxt = tally_hit;
      found_nxt = found_hit;
      if (in_scan_end) begin
        out_valid_nxt = 1'b1;
        status_nxt    = tally_hit;
        addr_out_nxt  = (tally_hit == STATUS_UNIQUE) ? found_hit : '0;
        fill_nxt      = '0;
        tally_nxt     = STATUS_NONE;
        found_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      tally_r     <= STATUS_NONE;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      tally_r     <= tally_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    addr_out_r <= addr_out_nxt;
    if (accept) begin
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
        window_r[k] <= window_r[k+1];
      end
      window_r[WIN_DEPTH-1] <= in_text_word;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_status  = status_r;
  assign out_match_address = addr_out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_BITS'(WIN_DEPTH))
    else $error("window fill beyond depth");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_scan_end) |=> out_valid_r)
    else $error("scan end beat produced no result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r != 2'd3))
    else $error("result status out of range");

  a_addr_unique_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != STATUS_UNIQUE) |-> (addr_out_r == '0))
    else $error("address reported for non-unique result");

  a_cleared_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_scan_end) |=> (fill_r == '0 && tally_r == STATUS_NONE))
    else $error("scan state not cleared after scan end");

endmodule
